// ===== src/bbc_pkg.sv =====
// Shared types and constants of the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;  // (
    localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;  // )
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;  // [
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;  // ]
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;  // {
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;  // }

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REASON_OK       = 3'd0,
        REASON_MISMATCH = 3'd1,
        REASON_NO_OPEN  = 3'd2,
        REASON_UNCLOSED = 3'd3,
        REASON_OVERFLOW = 3'd4
    } t_reason;

    // Classified character as it travels from the front to the back.
    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_kind kind;
        logic  last;
    } t_token;

endpackage

// ===== src/bbc_if.sv =====
// Request and result channel interfaces of the bracket balance checker.
interface bbc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_expr;

    modport source (output valid, output char_in, output end_of_expr, input ready);
    modport sink   (input valid, input char_in, input end_of_expr, output ready);
endinterface

interface bbc_rsp_if;
    logic       valid;
    logic       ready;
    logic       balanced;
    logic [2:0] reason;

    modport source (output valid, output balanced, output reason, input ready);
    modport sink   (input valid, input balanced, input reason, output ready);
endinterface

// ===== src/bracket_balance_checker_top.sv =====
// Top level of the bracket balance checker.
// The block takes an expression one character request per cycle on i_req, with
// end_of_expr set on the final character, and gives one result on o_rsp per
// expression: balanced, and a reason (0 ok, 1 mismatched kind, 2 close without
// open, 3 unclosed open, 4 stack overflow). The first fault is sticky; later
// characters of that expression are ignored, and the block clears itself after
// the final character. Throughput is one character per cycle while no final
// character waits on a full output register, set by the back stage, which
// does one push or pop of the bracket stack per cycle: the top of the stack
// sits in a register and the RAM read port always prefetches the entry below
// it. A character is loaded into the front register on acceptance, moves on
// into the queue and from there acts on the stack; a final character also
// loads the result register. A finished result waits in an output register
// while new characters keep flowing in; only a final character stalls when
// that register is still occupied.
module bracket_balance_checker_top #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_req_if.sink   i_req,
    bbc_rsp_if.source o_rsp
);

    logic            front_valid;
    bbc_pkg::t_token front_token;
    logic            q_ready;
    logic            q_valid;
    bbc_pkg::t_token q_token;
    logic            q_pop;

    // Accept and classify incoming characters.
    bbc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_valid   (front_valid),
        .o_token   (front_token)
    );

    // Decouple the front from stalls of the result side.
    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_token (front_token),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_token (q_token),
        .i_pop   (q_pop)
    );

    // Run the stack and hold the result until it is taken.
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_token    (q_token),
        .o_pop      (q_pop),
        .o_valid    (o_rsp.valid),
        .i_ready    (o_rsp.ready),
        .o_balanced (o_rsp.balanced),
        .o_reason   (o_rsp.reason)
    );

endmodule

// ===== src/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bbc_front.sv =====
// Front stage: accept a character request and classify it into a token.
module bbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bbc_req_if.sink           i_req,
    input  logic              i_q_ready,
    output logic              o_valid,
    output bbc_pkg::t_token   o_token
);

    logic            r_valid;
    logic            n_valid;
    bbc_pkg::t_token r_token;
    bbc_pkg::t_token n_token;
    logic            take;

    assign i_req.ready = !r_valid || i_q_ready;
    assign take        = i_req.valid && i_req.ready;

    always_comb begin
        n_token          = r_token;
        n_valid          = r_valid;
        if (i_q_ready) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid          = 1'b1;
            n_token.last     = i_req.end_of_expr;
            n_token.is_open  = 1'b0;
            n_token.is_close = 1'b0;
            n_token.kind     = bbc_pkg::KIND_NONE;
            case (i_req.char_in)
                bbc_pkg::CHAR_OPEN_ROUND: begin
                    n_token.is_open = 1'b1;
                    n_token.kind    = bbc_pkg::KIND_ROUND;
                end
                bbc_pkg::CHAR_OPEN_CURLY: begin
                    n_token.is_open = 1'b1;
                    n_token.kind    = bbc_pkg::KIND_CURLY;
                end
                bbc_pkg::CHAR_OPEN_SQUARE: begin
                    n_token.is_open = 1'b1;
                    n_token.kind    = bbc_pkg::KIND_SQUARE;
                end
                bbc_pkg::CHAR_CLOSE_ROUND: begin
                    n_token.is_close = 1'b1;
                    n_token.kind     = bbc_pkg::KIND_ROUND;
                end
                bbc_pkg::CHAR_CLOSE_CURLY: begin
                    n_token.is_close = 1'b1;
                    n_token.kind     = bbc_pkg::KIND_CURLY;
                end
                bbc_pkg::CHAR_CLOSE_SQUARE: begin
                    n_token.is_close = 1'b1;
                    n_token.kind     = bbc_pkg::KIND_SQUARE;
                end
                default: begin
                    n_token.kind = bbc_pkg::KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_token <= n_token;
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

// ===== src/bbc_queue.sv =====
// Two-entry token queue between the front and back stages.
module bbc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbc_pkg::t_token i_token,
    output logic            o_ready,
    output logic            o_valid,
    output bbc_pkg::t_token o_token,
    input  logic            i_pop
);

    bbc_pkg::t_token r_slot [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_token = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_token;
        end
    end

endmodule

// ===== src/bbc_back.sv =====
// Back stage: run the bracket stack and build the per-expression result.
module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bbc_pkg::t_token i_token,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_balanced,
    output logic [2:0]      o_reason
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]  r_depth;
    logic [CNT_W-1:0]  n_depth;
    bbc_pkg::t_reason  r_err;
    bbc_pkg::t_reason  n_err;
    bbc_pkg::t_kind    r_top;
    bbc_pkg::t_kind    n_top;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_balanced;
    logic              n_balanced;
    bbc_pkg::t_reason  r_reason;
    bbc_pkg::t_reason  n_reason;

    logic              out_free;
    logic              fire;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [CNT_W-1:0]  below_cnt;
    logic [1:0]        below_data;
    logic [CNT_W-1:0]  body_depth;
    bbc_pkg::t_reason  body_err;

    assign out_free = !r_out_valid || i_ready;
    assign fire     = i_valid && (!i_token.last || out_free);
    assign o_pop    = fire;

    // Holds entries of the stack; the top is mirrored in r_top.
    bbc_ram #(
        .WIDTH  (2),
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_token.kind),
        .i_raddr (raddr),
        .o_rdata (below_data)
    );

    always_comb begin
        body_depth  = r_depth;
        body_err    = r_err;
        n_top       = r_top;
        we          = 1'b0;
        waddr       = r_depth[ADDR_W-1:0];
        n_out_valid = r_out_valid && !i_ready;
        n_balanced  = r_balanced;
        n_reason    = r_reason;

        if (fire && (r_err == bbc_pkg::REASON_OK)) begin
            if (i_token.is_open) begin
                if (r_depth == CNT_W'(STACK_DEPTH)) begin
                    body_err = bbc_pkg::REASON_OVERFLOW;
                end else begin
                    we         = 1'b1;
                    n_top      = i_token.kind;
                    body_depth = r_depth + CNT_W'(1);
                end
            end else if (i_token.is_close) begin
                if (r_depth == '0) begin
                    body_err = bbc_pkg::REASON_NO_OPEN;
                end else begin
                    body_depth = r_depth - CNT_W'(1);
                    n_top      = bbc_pkg::t_kind'(below_data);
                    if (r_top != i_token.kind) begin
                        body_err = bbc_pkg::REASON_MISMATCH;
                    end
                end
            end
        end

        n_depth = body_depth;
        n_err   = body_err;
        if (fire && i_token.last) begin
            n_out_valid = 1'b1;
            n_reason    = body_err;
            if (body_err == bbc_pkg::REASON_OK && body_depth != '0) begin
                n_reason = bbc_pkg::REASON_UNCLOSED;
            end
            n_balanced = (n_reason == bbc_pkg::REASON_OK);
            n_depth    = '0;
            n_err      = bbc_pkg::REASON_OK;
        end

        // Prefetch the entry under the next top so a pop finds it ready.
        below_cnt = n_depth - CNT_W'(2);
        if ({1'b0, n_depth} >= (CNT_W + 1)'(2)) begin
            raddr = below_cnt[ADDR_W-1:0];
        end else begin
            raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_err       <= bbc_pkg::REASON_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_top      <= n_top;
        r_balanced <= n_balanced;
        r_reason   <= n_reason;
    end

    assign o_valid    = r_out_valid;
    assign o_balanced = r_balanced;
    assign o_reason   = r_reason;

endmodule

// ===== src/bbc_checker.sv =====
// Port-level checker of the bracket balance checker, bound to the top level.
module bbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_balanced,
    input logic [2:0] i_out_reason
);

    logic [3:0] r_pending;
    logic       in_last_fire;
    logic       out_fire;

    assign in_last_fire = i_in_valid && i_in_ready && i_in_last;
    assign out_fire     = i_out_valid && i_out_ready;

    // Count final characters accepted whose result is not yet taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({in_last_fire, out_fire})
                2'b10:   r_pending <= r_pending + 4'd1;
                2'b01:   r_pending <= r_pending - 4'd1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_balanced) && $stable(i_out_reason))
        else $error("stalled result changed");

    a_balanced_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_balanced == (i_out_reason == bbc_pkg::REASON_OK)))
        else $error("balanced flag disagrees with reason");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 4'd0)
        else $error("result without a final character");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_in_last      (i_req.end_of_expr),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_balanced (o_rsp.balanced),
    .i_out_reason   (o_rsp.reason)
);

// ===== tb/tb_bracket_balance_checker_top.sv =====
// Self-checking testbench for the bracket balance checker top level.
`timescale 1ns / 100ps

module tb_bracket_balance_checker_top;
    import bbc_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_PCT     = 31;
    // Window of counted requests in the random part during which both sides run flat out.
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 450;

    // One verdict per expression, as the result channel carries it.
    typedef struct {
        logic    balanced;
        t_reason reason;
    } verdict_t;

    // One row of the directed table. The typed flag marks a row whose verdict is
    // written out here; every other final row takes its verdict from the predictor.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       balanced;
        t_reason    reason;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
        // Zero byte and all-ones byte as lone expressions: nothing to balance.
        '{8'h00,             1'b1, 1'b1, 1'b1, REASON_OK},
        '{8'hFF,             1'b1, 1'b1, 1'b1, REASON_OK},
        // Each bracket pair on its own.
        '{CHAR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_ROUND,  1'b1, 1'b1, 1'b1, REASON_OK},
        '{CHAR_OPEN_CURLY,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_CURLY,  1'b1, 1'b1, 1'b1, REASON_OK},
        '{CHAR_OPEN_SQUARE,  1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_SQUARE, 1'b1, 1'b1, 1'b1, REASON_OK},
        // Close on an empty stack.
        '{CHAR_CLOSE_ROUND,  1'b1, 1'b1, 1'b0, REASON_NO_OPEN},
        // Kind mismatch.
        '{CHAR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_SQUARE, 1'b1, 1'b1, 1'b0, REASON_MISMATCH},
        // Open left at the end.
        '{CHAR_OPEN_SQUARE,  1'b1, 1'b1, 1'b0, REASON_UNCLOSED},
        // Mismatch is sticky: the later open and the close that would match are ignored.
        '{CHAR_OPEN_CURLY,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_ROUND,  1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_CURLY,  1'b1, 1'b1, 1'b0, REASON_MISMATCH},
        // Close-without-open is sticky: the open after it must not turn into unclosed.
        '{CHAR_CLOSE_CURLY,  1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_OPEN_ROUND,   1'b1, 1'b1, 1'b0, REASON_NO_OPEN},
        // Three kinds nested around a plain letter.
        '{CHAR_OPEN_ROUND,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_OPEN_SQUARE,  1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_OPEN_CURLY,   1'b0, 1'b0, 1'b0, REASON_OK},
        '{8'h61,             1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_CURLY,  1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_SQUARE, 1'b0, 1'b0, 1'b0, REASON_OK},
        '{CHAR_CLOSE_ROUND,  1'b1, 1'b0, 1'b0, REASON_OK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbc_req_if req_ch ();
    bbc_rsp_if rsp_ch ();

    bracket_balance_checker_top #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: its own bracket stack, fill level and sticky fault.
    t_kind   nest_stack [DEPTH];
    int      nest_depth = 0;
    t_reason fault      = REASON_OK;

    verdict_t   pending_verdicts [$];
    logic [7:0] expr_text [$];
    int         mismatch_count = 0;
    int         live_count     = 0;
    logic       random_phase   = 1'b0;
    logic       calm           = 1'b0;

    function automatic t_kind opener_kind(input logic [7:0] c);
        case (c)
            CHAR_OPEN_ROUND:  return KIND_ROUND;
            CHAR_OPEN_CURLY:  return KIND_CURLY;
            CHAR_OPEN_SQUARE: return KIND_SQUARE;
            default:          return KIND_NONE;
        endcase
    endfunction

    function automatic t_kind closer_kind(input logic [7:0] c);
        case (c)
            CHAR_CLOSE_ROUND:  return KIND_ROUND;
            CHAR_CLOSE_CURLY:  return KIND_CURLY;
            CHAR_CLOSE_SQUARE: return KIND_SQUARE;
            default:           return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] open_char(input t_kind k);
        case (k)
            KIND_ROUND: return CHAR_OPEN_ROUND;
            KIND_CURLY: return CHAR_OPEN_CURLY;
            default:    return CHAR_OPEN_SQUARE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input t_kind k);
        case (k)
            KIND_ROUND: return CHAR_CLOSE_ROUND;
            KIND_CURLY: return CHAR_CLOSE_CURLY;
            default:    return CHAR_CLOSE_SQUARE;
        endcase
    endfunction

    function automatic t_kind any_kind();
        return t_kind'($urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] any_bracket();
        return $urandom_range(0, 1) ? open_char(any_kind()) : close_char(any_kind());
    endfunction

    // Advance the predictor by one character. Return 1 on a final character,
    // with the verdict for the expression, and clear the state for the next one.
    function automatic logic feed_char(input logic [7:0] c, input logic last,
                                       output verdict_t v);
        t_kind   k;
        t_reason why;
        v.balanced = 1'b0;
        v.reason   = REASON_OK;
        if (fault == REASON_OK) begin
            k = opener_kind(c);
            if (k != KIND_NONE) begin
                // A full stack drops the push and marks overflow.
                if (nest_depth >= DEPTH) begin
                    fault = REASON_OVERFLOW;
                end else begin
                    nest_stack[nest_depth] = k;
                    nest_depth++;
                end
            end else begin
                k = closer_kind(c);
                if (k != KIND_NONE) begin
                    if (nest_depth == 0) begin
                        fault = REASON_NO_OPEN;
                    end else begin
                        // Pop even on a wrong kind; the fault then freezes everything.
                        nest_depth--;
                        if (nest_stack[nest_depth] != k) fault = REASON_MISMATCH;
                    end
                end
            end
        end
        if (!last) return 1'b0;
        why = fault;
        if (why == REASON_OK && nest_depth != 0) why = REASON_UNCLOSED;
        v.balanced = (why == REASON_OK);
        v.reason   = why;
        nest_depth = 0;
        fault      = REASON_OK;
        return 1'b1;
    endfunction

    // Offer one character request, idling first at random, and hold it until
    // the block takes it. On acceptance, advance the predictor and queue the
    // verdict of a final character: the typed one where the table gives it.
    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic typed, input verdict_t typed_v);
        verdict_t v;
        calm = random_phase && live_count >= CALM_FROM && live_count < CALM_TO;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.char_in     <= c;
        req_ch.end_of_expr <= last;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        // Count every accepted request.
        live_count++;
        if (feed_char(c, last, v)) pending_verdicts.push_back(typed ? typed_v : v);
    endtask

    task automatic send_text();
        verdict_t none;
        none.balanced = 1'b0;
        none.reason   = REASON_OK;
        for (int i = 0; i < expr_text.size(); i++)
            send_char(expr_text[i], i == expr_text.size() - 1, 1'b0, none);
    endtask

    // Build a well-formed expression with random filler, then break it in
    // about a third of the cases.
    function automatic void build_nested();
        t_kind open_q [$];
        int    steps;
        int    limit;
        int    pick;
        int    idx;
        steps = $urandom_range(1, 30);
        limit = $urandom_range(1, 10);
        expr_text = {};
        repeat (steps) begin
            pick = $urandom_range(0, 9);
            if (pick < 4 && open_q.size() < limit) begin
                open_q.push_back(any_kind());
                expr_text.push_back(open_char(open_q[$]));
            end else if (pick < 8 && open_q.size() > 0) begin
                expr_text.push_back(close_char(open_q.pop_back()));
            end else begin
                expr_text.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (open_q.size() > 0) expr_text.push_back(close_char(open_q.pop_back()));
        if (expr_text.size() == 0) expr_text.push_back(8'($urandom_range(0, 255)));
        idx = $urandom_range(0, expr_text.size() - 1);
        case ($urandom_range(0, 8))
            0: expr_text[idx] = any_bracket();
            1: if (expr_text.size() > 1) void'(expr_text.pop_back());
            2: expr_text.insert(idx, any_bracket());
            default: ;
        endcase
    endfunction

    // Raw bytes, about half of them brackets.
    function automatic void build_noise();
        expr_text = {};
        repeat ($urandom_range(1, 12))
            expr_text.push_back($urandom_range(0, 1) ? any_bracket()
                                                     : 8'($urandom_range(0, 255)));
    endfunction

    // Push to a chosen depth around the stack size, then close or leave it open.
    function automatic void build_deep(input int target, input logic close_all);
        t_kind open_q [$];
        expr_text = {};
        repeat (target) begin
            open_q.push_back(any_kind());
            expr_text.push_back(open_char(open_q[$]));
        end
        if (close_all)
            while (open_q.size() > 0) expr_text.push_back(close_char(open_q.pop_back()));
    endfunction

    // Time-zero values, so no input of the block is ever unknown.
    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.char_in     = 8'h00;
        req_ch.end_of_expr = 1'b0;
        rsp_ch.ready       = 1'b0;
    end

    // Result side: stall at random, and check each accepted result against the
    // oldest queued verdict.
    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with none expected: balanced %0b reason %0d",
                         $time, rsp_ch.balanced, rsp_ch.reason);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (rsp_ch.balanced !== want.balanced) begin
                    $display("%0t: balanced expected %0b actual %0b",
                             $time, want.balanced, rsp_ch.balanced);
                    mismatch_count++;
                end
                if (rsp_ch.reason !== want.reason) begin
                    $display("%0t: reason expected %0d actual %0d",
                             $time, want.reason, rsp_ch.reason);
                    mismatch_count++;
                end
            end
        end
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("tb_bracket_balance_checker_top NOT OK");
        $finish;
    end

    initial begin
        verdict_t typed_v;
        int       expr_no;
        int       pick;

        // Hold reset, then release it once.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        foreach (DIRECTED_ROWS[i]) begin
            typed_v.balanced = DIRECTED_ROWS[i].balanced;
            typed_v.reason   = DIRECTED_ROWS[i].reason;
            send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].typed, typed_v);
        end

        // Random expressions. Open with one overflow and one exactly full
        // balanced stack, so both stack limits are hit on every seed.
        random_phase = 1'b1;
        live_count   = 0;
        expr_no      = 0;
        while (live_count < RANDOM_ITEMS) begin
            if (expr_no == 0) begin
                build_deep(DEPTH + 1, 1'b1);
            end else if (expr_no == 1) begin
                build_deep(DEPTH, 1'b1);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    build_deep($urandom_range(DEPTH - 2, DEPTH + 2), 1'($urandom_range(0, 1)));
                else if (pick < 75)
                    build_nested();
                else
                    build_noise();
            end
            send_text();
            expr_no++;
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every queued verdict, then keep waiting a while to catch
        // any stray result.
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_bracket_balance_checker_top OK");
        end else begin
            $display("tb_bracket_balance_checker_top NOT OK");
        end
        $finish;
    end

endmodule
